[src/tvn_pkg.sv]
`default_nettype none
package tvn_pkg;

	// corner values
	typedef logic signed [31:0] corner_t;

	// stages inside one octave lane, and the full pipe with the summing stage
	localparam int LANE_STAGES = 9;
	localparam int PIPE_STAGES = LANE_STAGES + 1;

	// width of one octave's blended value
	localparam int OCT_W = 36;

	// hash constants, the polynomial ones reduced to the 31 bits that the result keeps
	localparam logic [31:0] ROW_MUL  = 32'd57;
	localparam logic [30:0] HASH_MUL = 31'd15731;
	localparam logic [30:0] HASH_ADD = 31'd789221;
	localparam logic [30:0] HASH_OFS = 31'd1376312589;
	localparam corner_t     ONE_Q30  = 32'sd1073741824;

	localparam logic [3:0]  WRAP_RESET = 4'd3;

endpackage
`default_nettype wire

[src/tileable_value_noise_fbm.sv]
// Tileable fractal value noise, one word per cycle while the receiver keeps up.
// Input channel: coord_x / coord_y (signed Q16.16) with coord_valid and
// coord_ready; a word is taken when both are high.
// Output channel: noise_value (signed Q2.30, saturated to +/-2^30) with
// noise_valid and noise_ready.
// cfg_we writes cfg_wdata into wrap_log2 (log2 of the base tiling period)
// in the same edge; write it only while the pipe is empty.
// Throughput: one word per cycle unless the receiver stalls, set by
// the ten-stage pipeline in which every octave lane has its own hash
// and blend multipliers.
// Each stage holds a valid bit and advances whenever the stage after it is
// empty or moving, so bubbles close up. When the receiver stalls the pipe
// fills, and coord_ready falls only once every stage holds a word.
// Reset clears all valid bits and sets wrap_log2 to three (eight cells).
`default_nettype none
module tileable_value_noise_fbm #(
	parameter int FRAC_BITS = 16,
	parameter int OCTAVES   = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [3:0]         cfg_wdata,
	input  wire logic               coord_valid,
	output logic                    coord_ready,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	output logic                    noise_valid,
	input  wire logic               noise_ready,
	output logic signed [31:0]      noise_value
);
	import tvn_pkg::*;

	localparam int SUM_W = OCT_W + $clog2(OCTAVES) + 1;
	localparam int N     = PIPE_STAGES;

	logic [3:0]   wrap_q;
	logic [N-1:0] vld_q;
	logic [N-1:0] en;
	logic signed [OCT_W-1:0] oct [OCTAVES];
	logic signed [SUM_W-1:0] sum;
	logic signed [31:0]      out_s9;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= WRAP_RESET;
		end else if (cfg_we) begin
			wrap_q <= cfg_wdata;
		end
	end

	// stage enables: move when empty or when the next stage moves
	always_comb begin
		en[N-1] = !vld_q[N-1] || noise_ready;
		for (int i = N - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= coord_valid;
			end
			for (int i = 1; i < N; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// octave lanes
	for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
		tvn_octave #(.FRAC_BITS(FRAC_BITS), .K(k)) u_oct (
			.clk,
			.en(en[LANE_STAGES-1:0]),
			.wrap_log2(wrap_q),
			.coord_x,
			.coord_y,
			.octave(oct[k])
		);
	end

	// octave sum and saturation
	always_comb begin
		sum = '0;
		for (int k = 0; k < OCTAVES; k++) begin
			sum = sum + SUM_W'(oct[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			if (sum > SUM_W'(ONE_Q30)) begin
				out_s9 <= ONE_Q30;
			end else if (sum < -SUM_W'(ONE_Q30)) begin
				out_s9 <= -ONE_Q30;
			end else begin
				out_s9 <= 32'(sum);
			end
		end
	end

	assign coord_ready = en[0];
	assign noise_valid = vld_q[N-1];
	assign noise_value = out_s9;

	// an empty output stage always lets a word in
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!noise_valid |-> coord_ready) else $error("input blocked with empty output");

	// a shown result is inside the saturated range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid |-> (noise_value <= ONE_Q30 && noise_value >= -ONE_Q30))
		else $error("result out of range");

	// a taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid && noise_ready && !vld_q[N-2] |=> !noise_valid)
		else $error("result repeated");

endmodule
`default_nettype wire

[src/tvn_hash.sv]
`default_nettype none
module tvn_hash (
	input  wire logic            clk,
	input  wire logic [4:0]      en,
	input  wire logic [31:0]     cx,
	input  wire logic [31:0]     cy,
	output tvn_pkg::corner_t     value
);
	import tvn_pkg::*;

	logic [31:0] n0;
	logic [31:0] n1;
	logic [30:0] n_s1, n_s2, n_s3;
	logic [30:0] nn_s2;
	logic [30:0] h_s3;
	logic [30:0] p_s4;
	logic [30:0] m;
	corner_t     value_s5;

	// lattice index folding
	assign n0 = cx + cy * ROW_MUL;
	assign n1 = (n0 << 13) ^ n0;
	assign m  = p_s4 + HASH_OFS;

	// polynomial, at most one multiply per stage, low 31 bits only
	always_ff @(posedge clk) begin
		if (en[0]) begin
			n_s1 <= n1[30:0];
		end
		if (en[1]) begin
			nn_s2 <= n_s1 * n_s1;
			n_s2  <= n_s1;
		end
		if (en[2]) begin
			h_s3 <= nn_s2 * HASH_MUL + HASH_ADD;
			n_s3 <= n_s2;
		end
		if (en[3]) begin
			p_s4 <= n_s3 * h_s3;
		end
		if (en[4]) begin
			value_s5 <= ONE_Q30 - $signed({1'b0, m});
		end
	end

	assign value = value_s5;

endmodule
`default_nettype wire

[src/tvn_octave.sv]
`default_nettype none
module tvn_octave #(
	parameter int FRAC_BITS = 16,
	parameter int K         = 0
) (
	input  wire logic                          clk,
	input  wire logic [tvn_pkg::LANE_STAGES-1:0] en,
	input  wire logic [3:0]                    wrap_log2,
	input  wire logic signed [31:0]            coord_x,
	input  wire logic signed [31:0]            coord_y,
	output logic signed [tvn_pkg::OCT_W-1:0]   octave
);
	import tvn_pkg::*;

	localparam int F = FRAC_BITS;

	logic signed [63:0] wx, wy;
	logic [4:0]         sh;
	logic [31:0]        pmask;
	logic [31:0]        cellx, celly;

	logic [31:0]  ix_s0, iy_s0, ix1_s0, iy1_s0;
	logic [F-1:0] fx_s0, fy_s0;
	logic [F-1:0] fx_s1, fy_s1, f2x_s1, f2y_s1;
	logic [F-1:0] sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5, sx_s6, sy_s6;
	logic [F-1:0] sxy_s3, sxy_s4, sxy_s5, sxy_s6;
	logic [2*F-1:0]   sqx, sqy, sxy_p;
	logic [F+1:0]     tx, ty;
	logic [2*F+1:0]   smx, smy;

	corner_t a, b, c, d;
	corner_t a_s6, a_s7;
	logic signed [32:0] dba_s6, dca_s6;
	logic signed [33:0] dd_s6;
	logic signed [F+33:0] px, py;
	logic signed [F+34:0] pxy;
	logic signed [33:0] tx_s7, ty_s7, txy_s7;
	logic signed [OCT_W-1:0] r;
	logic signed [OCT_W-1:0] oct_s8;

	// cell index and fraction, period mask
	assign wx    = 64'(coord_x) <<< K;
	assign wy    = 64'(coord_y) <<< K;
	assign sh    = 5'(wrap_log2) + 5'(K);
	assign pmask = ~(32'hFFFF_FFFF << sh);
	assign cellx = wx[F+31:F];
	assign celly = wy[F+31:F];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ix_s0  <= cellx & pmask;
			iy_s0  <= celly & pmask;
			ix1_s0 <= (cellx + 32'd1) & pmask;
			iy1_s0 <= (celly + 32'd1) & pmask;
			fx_s0  <= wx[F-1:0];
			fy_s0  <= wy[F-1:0];
		end
	end

	// four corner hashes
	tvn_hash u_ha (.clk, .en(en[5:1]), .cx(ix_s0),  .cy(iy_s0),  .value(a));
	tvn_hash u_hb (.clk, .en(en[5:1]), .cx(ix1_s0), .cy(iy_s0),  .value(b));
	tvn_hash u_hc (.clk, .en(en[5:1]), .cx(ix_s0),  .cy(iy1_s0), .value(c));
	tvn_hash u_hd (.clk, .en(en[5:1]), .cx(ix1_s0), .cy(iy1_s0), .value(d));

	// smoothstep: square, then times (3 - 2f)
	assign sqx   = fx_s0 * fx_s0;
	assign sqy   = fy_s0 * fy_s0;
	assign tx    = {2'b11, {F{1'b0}}} - {1'b0, fx_s1, 1'b0};
	assign ty    = {2'b11, {F{1'b0}}} - {1'b0, fy_s1, 1'b0};
	assign smx   = f2x_s1 * tx;
	assign smy   = f2y_s1 * ty;
	assign sxy_p = sx_s2 * sy_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			f2x_s1 <= sqx[2*F-1:F];
			f2y_s1 <= sqy[2*F-1:F];
			fx_s1  <= fx_s0;
			fy_s1  <= fy_s0;
		end
		if (en[2]) begin
			sx_s2 <= smx[2*F-1:F];
			sy_s2 <= smy[2*F-1:F];
		end
		if (en[3]) begin
			sxy_s3 <= sxy_p[2*F-1:F];
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
		end
		if (en[4]) begin
			sxy_s4 <= sxy_s3;
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;
		end
		if (en[5]) begin
			sxy_s5 <= sxy_s4;
			sx_s5  <= sx_s4;
			sy_s5  <= sy_s4;
		end
	end

	// corner differences
	always_ff @(posedge clk) begin
		if (en[6]) begin
			a_s6   <= a;
			dba_s6 <= 33'(b) - 33'(a);
			dca_s6 <= 33'(c) - 33'(a);
			dd_s6  <= 34'(a) - 34'(b) - 34'(c) + 34'(d);
			sx_s6  <= sx_s5;
			sy_s6  <= sy_s5;
			sxy_s6 <= sxy_s5;
		end
	end

	// weighted terms, floored by the shift
	assign px  = $signed({1'b0, sx_s6})  * dba_s6;
	assign py  = $signed({1'b0, sy_s6})  * dca_s6;
	assign pxy = $signed({1'b0, sxy_s6}) * dd_s6;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			a_s7   <= a_s6;
			tx_s7  <= 34'(px >>> F);
			ty_s7  <= 34'(py >>> F);
			txy_s7 <= 34'(pxy >>> F);
		end
	end

	// blend and octave weight
	assign r = OCT_W'(a_s7) + OCT_W'(tx_s7) + OCT_W'(ty_s7) + OCT_W'(txy_s7);

	always_ff @(posedge clk) begin
		if (en[8]) begin
			oct_s8 <= r >>> (K + 1);
		end
	end

	assign octave = oct_s8;

endmodule
`default_nettype wire

[bench/tileable_value_noise_fbm_tb.sv]
`default_nettype none
module tileable_value_noise_fbm_tb;
	import tvn_pkg::*;

	localparam int FB      = 16;
	localparam int OCT_N   = 4;
	localparam int N_RAND  = 1300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;
	logic coord_valid = 1'b0;
	logic coord_ready;
	logic signed [31:0] coord_x = '0;
	logic signed [31:0] coord_y = '0;
	logic noise_valid;
	logic noise_ready = 1'b0;
	logic signed [31:0] noise_value;

	tileable_value_noise_fbm dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.coord_valid(coord_valid), .coord_ready(coord_ready),
		.coord_x(coord_x), .coord_y(coord_y),
		.noise_valid(noise_valid), .noise_ready(noise_ready),
		.noise_value(noise_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor's copy of the tiling register
	logic [3:0] wrap_sh;
	logic signed [31:0] pending_noise[$];
	int n_err = 0;
	bit hold_long = 1'b0;

	// lattice hash, 32-bit wrapping arithmetic
	function automatic longint lattice_val(logic [31:0] cx, logic [31:0] cy);
		logic [31:0] n;
		logic [31:0] m;
		n = cx + cy * 32'd57;
		n = (n << 13) ^ n;
		m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
		return 64'sd1073741824 - longint'({32'd0, m});
	endfunction

	function automatic longint ease(longint f);
		longint f2;
		f2 = (f * f) >>> FB;
		return (f2 * ((64'sd3 <<< FB) - 2 * f)) >>> FB;
	endfunction

	// one octave of blended lattice noise
	function automatic longint octave_val(longint x, longint y, int k);
		longint vx, vy, sx, sy, sxy, a, b, c, d, r;
		logic [31:0] pm, ix, iy, ix1, iy1;
		pm = 32'((64'd1 << (wrap_sh + k)) - 1);
		vx = x <<< k;
		vy = y <<< k;
		ix = 32'(vx >>> FB) & pm;
		iy = 32'(vy >>> FB) & pm;
		ix1 = (ix + 1) & pm;
		iy1 = (iy + 1) & pm;
		a = lattice_val(ix, iy);
		b = lattice_val(ix1, iy);
		c = lattice_val(ix, iy1);
		d = lattice_val(ix1, iy1);
		sx = ease(vx & 64'hffff);
		sy = ease(vy & 64'hffff);
		sxy = (sx * sy) >>> FB;
		r = a + ((sx * (b - a)) >>> FB) + ((sy * (c - a)) >>> FB)
			+ ((sxy * (a - b - c + d)) >>> FB);
		return r;
	endfunction

	function automatic logic signed [31:0] fbm_noise(logic signed [31:0] cx,
			logic signed [31:0] cy);
		longint s;
		s = 0;
		for (int k = 0; k < OCT_N; k++)
			s += octave_val(longint'(cx), longint'(cy), k) >>> (k + 1);
		if (s > 64'sd1073741824) s = 64'sd1073741824;
		if (s < -64'sd1073741824) s = -64'sd1073741824;
		return 32'(s);
	endfunction

	// directed rows; check 0 means use the predictor
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		bit check;
		logic signed [31:0] want;
	} row_t;

	row_t rows[] = '{
		'{32'sd0, 32'sd0, 1'b1, -32'sd283660094},
		'{32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 32'sd0},
		'{32'h8000_0000, 32'h8000_0000, 1'b0, 32'sd0},
		'{32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'sd0},
		'{32'hffff_ffff, 32'h0000_0001, 1'b0, 32'sd0},
		'{32'h0000_ffff, 32'h0000_ffff, 1'b0, 32'sd0},
		'{32'h0000_8000, 32'h0000_8000, 1'b0, 32'sd0},
		'{32'hffff_0000, 32'h0001_0000, 1'b0, 32'sd0},
		'{32'h0008_0000, 32'h0008_0000, 1'b0, 32'sd0},
		'{32'hfff8_0000, 32'h0000_4000, 1'b0, 32'sd0},
		'{32'haaaa_aaaa, 32'h5555_5555, 1'b0, 32'sd0},
		'{32'h5555_5555, 32'haaaa_aaaa, 1'b0, 32'sd0}
	};

	// offer one word, held until accepted
	task automatic send_word(logic signed [31:0] x, logic signed [31:0] y);
		coord_x <= x;
		coord_y <= y;
		coord_valid <= 1'b1;
		pending_noise.push_back(fbm_noise(x, y));
		@(posedge clk);
		while (!coord_ready) @(posedge clk);
	endtask

	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (g > 0) begin
			coord_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain_and_set(logic [3:0] w);
		coord_valid <= 1'b0;
		@(posedge clk);
		while (pending_noise.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		wrap_sh = w;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random coordinate: mostly moderate, sometimes full range
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
			default: return 32'($urandom_range(0, 32'h0007_ffff)) - 32'sh0004_0000;
		endcase
	endfunction

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		logic signed [31:0] exp_v;
		if (arst_n && noise_valid && noise_ready) begin
			if (pending_noise.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected word %h", noise_value);
			end else begin
				exp_v = pending_noise.pop_front();
				if (exp_v !== noise_value) begin
					n_err++;
					if (n_err <= 10)
						$display("noise_value mismatch: exp %h got %h", exp_v, noise_value);
				end
			end
		end
		if (!arst_n || hold_long) noise_ready <= 1'b0;
		else noise_ready <= ($urandom_range(0, 9) < 7);
	end

	// one long receiver hold-off while the sender keeps offering
	initial begin
		wait (arst_n);
		repeat (600) @(posedge clk);
		hold_long = 1'b1;
		repeat (60) @(posedge clk);
		hold_long = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("** tileable_value_noise_fbm: FAILED **");
		$finish;
	end

	initial begin
		static logic [3:0] wraps[6] = '{4'd0, 4'd15, 4'd12, 4'd1, 4'd7, 4'd3};
		wrap_sh = WRAP_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed table at reset wrap
		foreach (rows[i]) begin
			send_word(rows[i].x, rows[i].y);
			if (rows[i].check) begin
				void'(pending_noise.pop_back());
				pending_noise.push_back(rows[i].want);
			end
		end
		// saturation-free zero point and an extreme corner under the largest wrap
		drain_and_set(4'd15);
		send_word(32'sd0, 32'sd0);
		send_word(32'h7fff_ffff, 32'h8000_0000);
		// random phases through several wrap settings
		foreach (wraps[p]) begin
			drain_and_set(wraps[p]);
			for (int i = 0; i < N_RAND / 6; i++) begin
				send_word(rand_coord(), rand_coord());
				if ($urandom_range(0, 4) == 0) idle_gap();
			end
		end
		coord_valid <= 1'b0;
		while (pending_noise.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (n_err == 0) $display("** tileable_value_noise_fbm: PASSED **");
		else $display("** tileable_value_noise_fbm: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
src/tvn_pkg.sv
src/tvn_hash.sv
src/tvn_octave.sv
src/tileable_value_noise_fbm.sv
bench/tileable_value_noise_fbm_tb.sv
